// ----- rtl/mdu_pkg.sv -----
// Shared codes for the multiply-divide unit.
`timescale 1ns / 1ps
package mdu_pkg;
  localparam int OperandBits = 32;
  localparam int StatusBits  = 2;

  typedef enum logic [0:0] {
    KIND_SIGNED   = 1'b0,
    KIND_UNSIGNED = 1'b1
  } kind_t;

  typedef enum logic [StatusBits-1:0] {
    ST_OK       = 2'd0,
    ST_DIVZERO  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;
endpackage

// ----- rtl/multiply_divide_unit.sv -----
// Pipelined multiply-divide unit: quotient of a full product by a divisor.
//
// Usage:
//   Input channel s_axis_*: one item per handshake carries the three operands in
//   tdata and the operation kind in tuser (0 signed truncating, 1 unsigned
//   rounded to nearest). Only the low DATA_WIDTH bits of each operand count.
//   Output channel m_axis_*: one result item per input item, in order, with the
//   quotient in tdata (upper bits zero) and the status code in tuser.
//   The stages are the operand register, multiplier, rounding add and range
//   check, one restoring divide step per quotient bit, and the sign and
//   saturation output register. One item enters every cycle while the output
//   does not stall; the rate is set by the single shared pipeline enable.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the block is ready in the next cycle.
`timescale 1ns / 1ps
module multiply_divide_unit
  import mdu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [3*OperandBits-1:0]   s_axis_tdata,  // multiplicand, multiplier, divisor
  input  logic                       s_axis_tuser,  // kind
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OperandBits-1:0]     m_axis_tdata,  // quotient
  output logic [StatusBits-1:0]      m_axis_tuser   // status
);
  localparam int W = DATA_WIDTH;

  typedef struct packed {
    logic         kind;
    logic         neg;
    logic         dz;
    logic         ovf;
    logic [W-1:0] c;
    logic [W-1:0] r;
    logic [W-1:0] lo;
  } div_stage_t;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [W-1:0] in_a, in_b, in_c;
  assign in_a = s_axis_tdata[W-1:0];
  assign in_b = s_axis_tdata[OperandBits+W-1:OperandBits];
  assign in_c = s_axis_tdata[2*OperandBits+W-1:2*OperandBits];

  // operand stage
  logic         v0, kind0, neg0, dz0;
  logic [W-1:0] a0, b0, c0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
    if (en) begin
      kind0 <= s_axis_tuser;
      dz0   <= (in_c == '0);
      if (s_axis_tuser == KIND_SIGNED) begin
        a0   <= in_a[W-1] ? (~in_a + W'(1)) : in_a;
        b0   <= in_b[W-1] ? (~in_b + W'(1)) : in_b;
        c0   <= in_c[W-1] ? (~in_c + W'(1)) : in_c;
        neg0 <= in_a[W-1] ^ in_b[W-1] ^ in_c[W-1];
      end else begin
        a0   <= in_a;
        b0   <= in_b;
        c0   <= in_c;
        neg0 <= 1'b0;
      end
    end
  end

  // multiply stage
  logic           v1, kind1, neg1, dz1;
  logic [W-1:0]   c1;
  logic [2*W-1:0] p1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      kind1 <= kind0;
      neg1  <= neg0;
      dz1   <= dz0;
      c1    <= c0;
      p1    <= (2*W)'(a0) * (2*W)'(b0);
    end
  end

  // rounding and range stage
  logic [2*W-1:0] dividend;
  assign dividend = p1 + ((kind1 == KIND_UNSIGNED) ? {{(W+1){1'b0}}, c1[W-1:1]} : '0);

  logic       dv [0:W];
  div_stage_t ds [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v1;
    end
    if (en) begin
      ds[0].kind <= kind1;
      ds[0].neg  <= neg1;
      ds[0].dz   <= dz1;
      ds[0].ovf  <= (dividend[2*W-1:W] >= c1);
      ds[0].c    <= c1;
      ds[0].r    <= dividend[2*W-1:W];
      ds[0].lo   <= dividend[W-1:0];
    end
  end

  // one restoring divide step per quotient bit
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0] t;
    logic       ge;
    assign t  = {ds[k].r, ds[k].lo[W-1]};
    assign ge = (t >= {1'b0, ds[k].c});
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
      if (en) begin
        ds[k+1].kind <= ds[k].kind;
        ds[k+1].neg  <= ds[k].neg;
        ds[k+1].dz   <= ds[k].dz;
        ds[k+1].ovf  <= ds[k].ovf;
        ds[k+1].c    <= ds[k].c;
        ds[k+1].r    <= ge ? W'(t - {1'b0, ds[k].c}) : t[W-1:0];
        ds[k+1].lo   <= {ds[k].lo[W-2:0], ge};
      end
    end
  end

  // sign and saturation
  localparam logic [W-1:0] SMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMin = {1'b1, {(W-1){1'b0}}};

  div_stage_t   f;
  logic [W-1:0] q_next;
  status_t      st_next;
  assign f = ds[W];

  always_comb begin
    q_next  = f.lo;
    st_next = ST_OK;
    if (f.dz) begin
      q_next  = '1;
      st_next = ST_DIVZERO;
    end else if (f.kind == KIND_UNSIGNED) begin
      if (f.ovf) begin
        q_next  = '1;
        st_next = ST_OVERFLOW;
      end
    end else if (f.neg) begin
      if (f.ovf || f.lo > SMin) begin
        q_next  = SMin;
        st_next = ST_OVERFLOW;
      end else begin
        q_next = ~f.lo + W'(1);
      end
    end else if (f.ovf || f.lo[W-1]) begin
      q_next  = SMax;
      st_next = ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv[W];
    end
    if (en) begin
      m_axis_tdata <= OperandBits'(q_next);
      m_axis_tuser <= st_next;
    end
  end
endmodule

// ----- rtl/multiply_divide_unit_checker.sv -----
// Port-level assertions for the multiply-divide unit, bound to the top level.
`timescale 1ns / 1ps
module multiply_divide_unit_props
  import mdu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OperandBits-1:0]   m_axis_tdata,
  input logic [StatusBits-1:0]    m_axis_tuser
);
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_DIVZERO ||
                       m_axis_tuser == ST_OVERFLOW))
    else $error("undefined status code");

  a_divzero_ones: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_DIVZERO) |->
      (m_axis_tdata[DATA_WIDTH-1:0] == {DATA_WIDTH{1'b1}}))
    else $error("zero divisor quotient not all ones");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is free");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
endmodule

bind multiply_divide_unit multiply_divide_unit_props #(
  .DATA_WIDTH(DATA_WIDTH)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
